/* design/msb_first_bit_buffer_defines.svh */
// assertion macros for the msb-first bit buffer
// used by the top level; needs clk and rst_n in the scope of each use
`ifndef MSB_FIRST_BIT_BUFFER_DEFINES_SVH
`define MSB_FIRST_BIT_BUFFER_DEFINES_SVH
`ifndef SYNTH
// antecedent implies consequent in the same cycle
`define MBB_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("msb_first_bit_buffer check failed");
// antecedent implies consequent in the next cycle
`define MBB_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("msb_first_bit_buffer check failed");
`else
`define MBB_ASSERT_IMP(label, ante, cons)
`define MBB_ASSERT_NXT(label, ante, cons)
`endif
`endif

/* design/mbb_pkg.sv */
// shared types and constants for the msb-first bit buffer
// no dependencies; used by mbb_merge, the top level and the bench
package mbb_pkg;

  localparam int CAPACITY_BYTES_DEF = 256;
  localparam logic [3:0] MAX_COUNT = 4'd8;
  localparam logic [7:0] BYTE_MSB = 8'd128;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_SET    = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_READ   = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_t;

  typedef struct packed {
    opcode_t     opcode;
    logic [10:0] position;
    logic [7:0]  value;
    logic [3:0]  count;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  read_value;
    logic [11:0] length_bits;
    logic        overflow;
  } out_item_t;

  // operation context handed from the control to the byte-pair merge
  typedef struct packed {
    opcode_t    opcode;
    logic [2:0] offset;
    logic [3:0] n;
    logic [7:0] value;
  } op_ctx_t;

endpackage

/* design/mbb_bank.sv */
// one byte bank: single write port, single registered read port
// depends on nothing; the top level holds an even and an odd bank
module mbb_bank #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* design/mbb_merge.sv */
// merge of one operation into a pair of adjacent bytes, msb first
// depends on mbb_pkg for the opcode and context types
module mbb_merge (
  input  mbb_pkg::op_ctx_t ctx,
  input  logic [7:0]       byte_hi,
  input  logic [7:0]       byte_lo,
  output logic [7:0]       new_hi,
  output logic [7:0]       new_lo,
  output logic [7:0]       rd_val
);

  logic [15:0] win;
  logic [15:0] ins;
  logic [15:0] bitm;
  logic [15:0] shifted;
  logic [15:0] merged;
  logic [7:0]  aligned;
  logic [3:0]  gap;

  always_comb begin
    win     = {byte_hi, byte_lo};
    gap     = mbb_pkg::MAX_COUNT - ctx.n;
    // low n bits of value moved to the top of the byte
    aligned = ctx.value << gap;
    ins     = {aligned, 8'h00} >> ctx.offset;
    bitm    = {mbb_pkg::BYTE_MSB, 8'h00} >> ctx.offset;
    shifted = win << ctx.offset;
    merged  = win;
    rd_val  = 8'h00;
    unique case (ctx.opcode)
      mbb_pkg::OP_APPEND: merged = win | ins;
      mbb_pkg::OP_SET:    merged = win | bitm;
      mbb_pkg::OP_CLEAR:  merged = win & ~bitm;
      mbb_pkg::OP_READ:   rd_val = shifted[15:8] >> gap;
      default:            merged = win;
    endcase
    new_hi = merged[15:8];
    new_lo = merged[7:0];
  end

endmodule

/* design/msb_first_bit_buffer.sv */
// msb-first bit buffer: each item passes a bank read, then a merge and write back;
// the result strobe is registered at the end of the merge state, no stall from the receiver.
// busy is high in the merge state, so a new item is not taken until the last one is merged.
// after reset a clearing pass zeroes every entry of the two byte banks
// with busy high; the append pointer resets to zero.
// depends on mbb_pkg, mbb_bank, mbb_merge and msb_first_bit_buffer_defines.svh
`include "msb_first_bit_buffer_defines.svh"
module msb_first_bit_buffer #(
  parameter int CAPACITY_BYTES = mbb_pkg::CAPACITY_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  mbb_pkg::in_item_t   in_item,
  output logic                busy,
  output logic                out_valid,
  output mbb_pkg::out_item_t  out_item
);

  localparam int CAP_BITS   = CAPACITY_BYTES * 8;
  localparam int PTR_W      = $clog2(CAP_BITS + 1);
  localparam int BIT_W      = ((PTR_W > 11) ? PTR_W : 11) + 1;
  localparam int BYTE_AW    = BIT_W - 3;
  localparam int BANK_DEPTH = (CAPACITY_BYTES + 1) / 2;
  localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  localparam logic [PTR_W-1:0]   CAP_PTR  = PTR_W'(CAP_BITS);
  localparam logic [BYTE_AW:0]   CAP_BYTE = (BYTE_AW + 1)'(CAPACITY_BYTES);
  localparam logic [BANK_AW-1:0] CLR_LAST = BANK_AW'(BANK_DEPTH - 1);

  mbb_pkg::state_t    state_r, state_nxt;
  logic [PTR_W-1:0]   ptr_r, ptr_nxt;
  logic [BANK_AW-1:0] clr_r, clr_nxt;
  mbb_pkg::op_ctx_t   ctx_r;
  logic               a0_odd_r;
  logic               hi_ok_r, lo_ok_r;
  logic [BANK_AW-1:0] even_idx_r, odd_idx_r;
  logic               out_valid_r;
  mbb_pkg::out_item_t out_item_r;

  logic               accept;
  logic [BIT_W-1:0]   base;
  logic [BYTE_AW-1:0] a0;
  logic [BYTE_AW:0]   a1;
  logic [BYTE_AW-1:0] half;
  logic [BYTE_AW-1:0] even_full;
  logic [BANK_AW-1:0] rd_even_idx, rd_odd_idx;
  logic [3:0]         n_in;

  logic [7:0]         rd_even, rd_odd;
  logic [7:0]         byte_hi, byte_lo;
  logic [7:0]         new_hi, new_lo, rd_val;

  logic               wr_op;
  logic               we_even, we_odd;
  logic [BANK_AW-1:0] wa_even, wa_odd;
  logic [7:0]         wd_even, wd_odd;

  logic [PTR_W-1:0]   room, n_ext, stored;
  logic               is_app, ovf;

  // accept and address decode of the incoming item
  always_comb begin
    accept      = start && (state_r == mbb_pkg::ST_IDLE);
    base        = (in_item.opcode == mbb_pkg::OP_APPEND) ? BIT_W'(ptr_r)
                                                         : BIT_W'(in_item.position);
    a0          = base[BIT_W-1:3];
    a1          = {1'b0, a0} + 1'b1;
    half        = a0 >> 1;
    even_full   = half + BYTE_AW'(a0[0]);
    rd_even_idx = even_full[BANK_AW-1:0];
    rd_odd_idx  = half[BANK_AW-1:0];
    n_in        = (in_item.count > mbb_pkg::MAX_COUNT) ? mbb_pkg::MAX_COUNT : in_item.count;
  end

  // byte pair from the banks, bytes past capacity read as zero
  always_comb begin
    byte_hi = a0_odd_r ? rd_odd : rd_even;
    byte_lo = a0_odd_r ? rd_even : rd_odd;
    if (!hi_ok_r) begin
      byte_hi = 8'h00;
    end
    if (!lo_ok_r) begin
      byte_lo = 8'h00;
    end
  end

  mbb_merge u_merge (
    .ctx     (ctx_r),
    .byte_hi (byte_hi),
    .byte_lo (byte_lo),
    .new_hi  (new_hi),
    .new_lo  (new_lo),
    .rd_val  (rd_val)
  );

  // write back, or zero fill during the clearing pass
  always_comb begin
    wr_op = (state_r == mbb_pkg::ST_EXEC) && (ctx_r.opcode != mbb_pkg::OP_READ);
    if (state_r == mbb_pkg::ST_CLEAR) begin
      we_even = 1'b1;
      we_odd  = 1'b1;
      wa_even = clr_r;
      wa_odd  = clr_r;
      wd_even = 8'h00;
      wd_odd  = 8'h00;
    end else begin
      we_even = wr_op && (a0_odd_r ? lo_ok_r : hi_ok_r);
      we_odd  = wr_op && (a0_odd_r ? hi_ok_r : lo_ok_r);
      wa_even = even_idx_r;
      wa_odd  = odd_idx_r;
      wd_even = a0_odd_r ? new_lo : new_hi;
      wd_odd  = a0_odd_r ? new_hi : new_lo;
    end
  end

  mbb_bank #(.DEPTH(BANK_DEPTH), .AW(BANK_AW)) u_bank_even (
    .clk   (clk),
    .we    (we_even),
    .waddr (wa_even),
    .wdata (wd_even),
    .raddr (rd_even_idx),
    .rdata (rd_even)
  );

  mbb_bank #(.DEPTH(BANK_DEPTH), .AW(BANK_AW)) u_bank_odd (
    .clk   (clk),
    .we    (we_odd),
    .waddr (wa_odd),
    .wdata (wd_odd),
    .raddr (rd_odd_idx),
    .rdata (rd_odd)
  );

  // append pointer and overflow
  always_comb begin
    is_app  = (ctx_r.opcode == mbb_pkg::OP_APPEND);
    room    = CAP_PTR - ptr_r;
    n_ext   = PTR_W'(ctx_r.n);
    ovf     = is_app && (n_ext > room);
    stored  = ovf ? room : n_ext;
    ptr_nxt = ptr_r;
    if ((state_r == mbb_pkg::ST_EXEC) && is_app) begin
      ptr_nxt = ptr_r + stored;
    end
  end

  // sequencer: clearing pass, idle, merge
  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    unique case (state_r)
      mbb_pkg::ST_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == CLR_LAST) begin
          state_nxt = mbb_pkg::ST_IDLE;
        end
      end
      mbb_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = mbb_pkg::ST_EXEC;
        end
      end
      mbb_pkg::ST_EXEC: state_nxt = mbb_pkg::ST_IDLE;
      default:          state_nxt = mbb_pkg::ST_CLEAR;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mbb_pkg::ST_CLEAR;
      clr_r       <= '0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= (state_r == mbb_pkg::ST_EXEC);
    end
  end

  // item context captured at accept
  always_ff @(posedge clk) begin
    if (accept) begin
      ctx_r.opcode <= in_item.opcode;
      ctx_r.offset <= base[2:0];
      ctx_r.n      <= n_in;
      ctx_r.value  <= in_item.value;
      a0_odd_r     <= a0[0];
      hi_ok_r      <= ({1'b0, a0} < CAP_BYTE);
      lo_ok_r      <= (a1 < CAP_BYTE);
      even_idx_r   <= rd_even_idx;
      odd_idx_r    <= rd_odd_idx;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state_r == mbb_pkg::ST_EXEC) begin
      out_item_r.read_value  <= rd_val;
      out_item_r.length_bits <= 12'(ptr_nxt);
      out_item_r.overflow    <= ovf;
    end
  end

  assign busy      = (state_r != mbb_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // checks
  `MBB_ASSERT_NXT(a_accept_busy, accept, busy && !out_valid)
  `MBB_ASSERT_NXT(a_exec_result, state_r == mbb_pkg::ST_EXEC, out_valid)
  `MBB_ASSERT_IMP(a_ptr_bound, 1'b1, ptr_r <= CAP_PTR)
  `MBB_ASSERT_IMP(a_ovf_full, out_valid && out_item.overflow, out_item.length_bits == 12'(CAP_PTR))

endmodule

/* bench/tb.sv */
// self-checking bench for msb_first_bit_buffer: directed then random append, set, clear and read items
// a scoreboard class predicts every result and compares it as it leaves the block
// depends on mbb_pkg and the msb_first_bit_buffer rtl
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_BITS = mbb_pkg::CAPACITY_BYTES_DEF * 8;
  localparam int STALL_LIMIT = 1000;
  localparam int RANDOM_ITEMS = 800;

  // tracks the bit store and the results it owes
  class bit_store_tracker;
    bit [7:0] store_bytes [mbb_pkg::CAPACITY_BYTES_DEF];
    int unsigned fill_bits;
    mbb_pkg::out_item_t owed_results[$];
    int mismatches;
    int checked;
    int overflows;
    int op_counts [4];

    function new();
      foreach (store_bytes[i]) store_bytes[i] = '0;
      fill_bits = 0;
      mismatches = 0;
      checked = 0;
      overflows = 0;
      foreach (op_counts[i]) op_counts[i] = 0;
    endfunction

    // apply one accepted item and queue the result it should produce
    function void note_item(mbb_pkg::in_item_t it);
      mbb_pkg::out_item_t want;
      int unsigned n;
      int unsigned p;
      want = '0;
      n = (it.count > mbb_pkg::MAX_COUNT) ? mbb_pkg::MAX_COUNT : it.count;
      op_counts[it.opcode]++;
      case (it.opcode)
        mbb_pkg::OP_APPEND: begin
          for (int i = 0; i < n; i++) begin
            if (fill_bits < STORE_BITS) begin
              if (it.value[n - 1 - i])
                store_bytes[fill_bits >> 3] |= mbb_pkg::BYTE_MSB >> (fill_bits % 8);
              fill_bits++;
            end else begin
              want.overflow = 1'b1;
            end
          end
        end
        mbb_pkg::OP_SET: begin
          if (it.position < STORE_BITS)
            store_bytes[it.position >> 3] |= mbb_pkg::BYTE_MSB >> (it.position % 8);
        end
        mbb_pkg::OP_CLEAR: begin
          if (it.position < STORE_BITS)
            store_bytes[it.position >> 3] &= ~(mbb_pkg::BYTE_MSB >> (it.position % 8));
        end
        default: begin
          for (int i = 0; i < n; i++) begin
            p = it.position + i;
            want.read_value = {want.read_value[6:0],
                               (p < STORE_BITS) && store_bytes[p >> 3][7 - (p % 8)]};
          end
        end
      endcase
      want.length_bits = fill_bits[11:0];
      if (want.overflow) overflows++;
      owed_results = {owed_results, want};
    endfunction

    // compare one result against the oldest owed one
    function void check_result(mbb_pkg::out_item_t got);
      mbb_pkg::out_item_t want;
      if (owed_results.size() == 0) begin
        $display("%0t: unexpected result read_value=%h length_bits=%0d overflow=%b",
                 $time, got.read_value, got.length_bits, got.overflow);
        mismatches++;
        return;
      end
      want = owed_results.pop_front();
      checked++;
      if (got.read_value !== want.read_value) begin
        $display("%0t: read_value expected %h actual %h", $time, want.read_value,
                 got.read_value);
        mismatches++;
      end
      if (got.length_bits !== want.length_bits) begin
        $display("%0t: length_bits expected %0d actual %0d", $time, want.length_bits,
                 got.length_bits);
        mismatches++;
      end
      if (got.overflow !== want.overflow) begin
        $display("%0t: overflow expected %b actual %b", $time, want.overflow, got.overflow);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic start;
  mbb_pkg::in_item_t in_item;
  logic busy;
  logic out_valid;
  mbb_pkg::out_item_t out_item;

  bit_store_tracker tracker;
  int idle_cycles;
  bit steady_feed;

  msb_first_bit_buffer uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .in_item(in_item),
    .busy(busy),
    .out_valid(out_valid),
    .out_item(out_item)
  );

  // clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // item and result monitors
  always @(posedge clk) begin
    if (rst_n && start && !busy) tracker.note_item(in_item);
    if (rst_n && out_valid === 1'b1) tracker.check_result(out_item);
  end

  // watchdog on cycles where nothing moves
  always @(posedge clk) begin
    if ((start && !busy) || out_valid === 1'b1) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic mbb_pkg::in_item_t make_item(mbb_pkg::opcode_t op, int pos, int val,
                                                  int cnt);
    mbb_pkg::in_item_t it;
    it.opcode = op;
    it.position = pos[10:0];
    it.value = val[7:0];
    it.count = cnt[3:0];
    return it;
  endfunction

  // random item, half of the positions near the append pointer
  function automatic mbb_pkg::in_item_t random_item();
    int r;
    int pos;
    mbb_pkg::opcode_t op;
    r = $urandom_range(0, 99);
    if (r < 50) op = mbb_pkg::OP_APPEND;
    else if (r < 62) op = mbb_pkg::OP_SET;
    else if (r < 74) op = mbb_pkg::OP_CLEAR;
    else op = mbb_pkg::OP_READ;
    if ($urandom_range(0, 1)) begin
      pos = int'(tracker.fill_bits) + $urandom_range(0, 24) - 12;
      if (pos < 0) pos = 0;
      if (pos > 2047) pos = 2047;
    end else begin
      pos = $urandom_range(0, 2047);
    end
    return make_item(op, pos, $urandom_range(0, 255), $urandom_range(0, 15));
  endfunction

  // hold start high with the item until the block takes it
  task automatic send_item(mbb_pkg::in_item_t it, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // stop sending and wait until every owed result has come back
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (tracker.owed_results.size() != 0);
  endtask

  function automatic int draw_gap();
    return steady_feed ? 0 : $urandom_range(0, 14);
  endfunction

  initial begin
    tracker = new();
    idle_cycles = 0;
    steady_feed = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed items: empty read, clipped counts, merge ahead of pointer, store end
    send_item(make_item(mbb_pkg::OP_READ, 0, 0, 8), 0);
    send_item(make_item(mbb_pkg::OP_APPEND, 0, 8'hFF, 8), 0);
    send_item(make_item(mbb_pkg::OP_APPEND, 0, 8'hFF, 0), 1);
    send_item(make_item(mbb_pkg::OP_APPEND, 0, 8'hA5, 15), 0);
    send_item(make_item(mbb_pkg::OP_SET, 20, 0, 1), 2);
    send_item(make_item(mbb_pkg::OP_APPEND, 0, 8'h00, 8), 0);
    send_item(make_item(mbb_pkg::OP_READ, 16, 0, 8), 0);
    send_item(make_item(mbb_pkg::OP_CLEAR, 0, 0, 1), 3);
    send_item(make_item(mbb_pkg::OP_READ, 0, 0, 0), 0);
    send_item(make_item(mbb_pkg::OP_READ, 0, 0, 12), 0);
    send_item(make_item(mbb_pkg::OP_SET, 2047, 8'hFF, 8), 0);
    send_item(make_item(mbb_pkg::OP_READ, 2044, 0, 8), 0);
    send_item(make_item(mbb_pkg::OP_READ, 2047, 0, 1), 1);
    send_item(make_item(mbb_pkg::OP_CLEAR, 2047, 0, 1), 0);
    send_item(make_item(mbb_pkg::OP_READ, 2047, 0, 8), 0);
    send_item(make_item(mbb_pkg::OP_APPEND, 2047, 8'h01, 1), 0);
    send_item(make_item(mbb_pkg::OP_APPEND, 1365, 8'h7F, 7), 0);
    send_item(make_item(mbb_pkg::OP_READ, 24, 0, 16), 0);
    send_item(make_item(mbb_pkg::OP_SET, 1365, 0, 9), 0);
    send_item(make_item(mbb_pkg::OP_CLEAR, 682, 8'h80, 4), 0);
    send_item(make_item(mbb_pkg::OP_READ, 1360, 0, 8), 0);

    // let the block go quiet once before random traffic
    drain_results();

    // random traffic, idling mode reconsidered every 50 items
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 50 == 0) steady_feed = ($urandom_range(0, 9) < 3);
      send_item(random_item(), draw_gap());
    end

    // wait for the last results and a short tail
    drain_results();
    repeat (4) @(posedge clk);

    $display("ran %0d appends, %0d sets, %0d clears, %0d reads; %0d results checked",
             tracker.op_counts[mbb_pkg::OP_APPEND], tracker.op_counts[mbb_pkg::OP_SET],
             tracker.op_counts[mbb_pkg::OP_CLEAR], tracker.op_counts[mbb_pkg::OP_READ],
             tracker.checked);
    $display("append pointer ended at %0d bits, %0d appends ran past capacity",
             tracker.fill_bits, tracker.overflows);
    if (tracker.mismatches == 0 && tracker.owed_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

/* msb_first_bit_buffer.f */
+incdir+design
design/mbb_pkg.sv
design/mbb_bank.sv
design/mbb_merge.sv
design/msb_first_bit_buffer.sv
bench/tb.sv
